// ===== sv/acba_pkg.sv =====
`default_nettype none

package acba_pkg;

    localparam int unsigned WordW     = 32;
    localparam int unsigned CfgIdxW   = 3;
    localparam int unsigned InDataW   = 104;
    localparam int unsigned OutDataW  = 136;

    localparam logic [WordW-1:0] PageMask    = 32'd4095;
    localparam logic [WordW-1:0] ChunkReset  = 32'd16384;
    localparam logic [WordW-1:0] TrimCeiling = 32'hFFFF_FFFC;
    localparam logic [WordW-1:0] WordMax     = 32'hFFFF_FFFF;

    localparam logic [WordW-1:0] ArenaLimitReset  = 32'd33554432;
    localparam logic [WordW-1:0] MinCommitReset   = 32'd262144;
    localparam logic [WordW-1:0] GrowTicksReset   = 32'd100;
    localparam logic [WordW-1:0] ShrinkTicksReset = 32'd1000;
    localparam logic [WordW-1:0] ChunkMaxReset    = 32'd262144;
    localparam logic [WordW-1:0] ChunkMinReset    = 32'd8192;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_TRIM  = 2'd1,
        OP_FLUSH = 2'd2,
        OP_NOP   = 2'd3
    } acba_op_t;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_ARENA_LIMIT  = 3'd0,
        CFG_MIN_COMMIT   = 3'd1,
        CFG_SHRINK_FLUSH = 3'd2,
        CFG_GROW_TICKS   = 3'd3,
        CFG_SHRINK_TICKS = 3'd4,
        CFG_CHUNK_CEIL   = 3'd5,
        CFG_CHUNK_FLOOR  = 3'd6
    } acba_cfg_idx_t;

    typedef struct packed {
        logic [WordW-1:0] arena_limit;
        logic [WordW-1:0] min_commit_bytes;
        logic             shrink_on_flush;
        logic [WordW-1:0] grow_tick_limit;
        logic [WordW-1:0] shrink_tick_limit;
        logic [WordW-1:0] chunk_ceiling;
        logic [WordW-1:0] chunk_floor;
    } acba_cfg_t;

    typedef struct packed {
        logic [WordW-1:0] next_free;
        logic [WordW-1:0] commit_level;
        logic [WordW-1:0] chunk_size;
        logic [WordW-1:0] last_commit_tick;
    } acba_state_t;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [WordW-1:0] request_bytes;
        logic [WordW-1:0] tick_now;
        logic             commit_granted;
        logic [WordW-1:0] free_from;
    } acba_req_t;

    typedef struct packed {
        logic             granted;
        logic [WordW-1:0] block_offset;
        logic [WordW-1:0] commit_grow_bytes;
        logic             did_flush;
        logic [WordW-1:0] commit_level_out;
        logic [WordW-1:0] next_free_out;
    } acba_res_t;

endpackage

`default_nettype wire

// ===== sv/acba_step.sv =====
`default_nettype none

module acba_step import acba_pkg::*; (
    input  acba_cfg_t   cfg,
    input  acba_state_t state,
    input  acba_req_t   req,
    output acba_state_t state_next,
    output acba_res_t   res
);

    logic [WordW:0]   end_sum;
    logic             room_fail;
    logic             need_commit;
    logic [WordW-1:0] gap;
    logic [WordW-1:0] chunk_new;
    logic [WordW:0]   region_a;
    logic [WordW+1:0] span;
    logic [WordW+1:0] region_b;
    logic [WordW+1:0] region_pg;
    logic [WordW+2:0] commit_sum;
    logic [WordW-1:0] commit_new;
    logic             alloc_ok;
    logic [WordW:0]   trim_sum;
    logic [WordW-1:0] trim_val;
    acba_state_t      flushed;

    always_comb begin
        end_sum     = {1'b0, state.next_free} + {1'b0, req.request_bytes};
        room_fail   = end_sum[WordW] || (end_sum >= {1'b0, cfg.arena_limit});
        need_commit = end_sum[WordW-1:0] > state.commit_level;
        gap         = req.tick_now - state.last_commit_tick;

        // adapt the chunk to how busy commits have been
        chunk_new = state.chunk_size;
        if (gap < cfg.grow_tick_limit) begin
            if (state.chunk_size < cfg.chunk_ceiling) begin
                chunk_new = state.chunk_size[WordW-1] ? WordMax
                                                      : {state.chunk_size[WordW-2:0], 1'b0};
            end
        end else if (gap > cfg.shrink_tick_limit) begin
            if (state.chunk_size > cfg.chunk_floor) begin
                chunk_new = {1'b0, state.chunk_size[WordW-1:1]};
            end
        end

        region_a = {1'b0, chunk_new};
        if ({1'b0, chunk_new} < {1'b0, req.request_bytes}) begin
            region_a = {req.request_bytes, 1'b0};
        end
        span = {1'b0, region_a} + {2'b00, state.commit_level};
        region_b = {1'b0, region_a};
        if (span >= {2'b00, cfg.arena_limit}) begin
            region_b = (state.commit_level < cfg.arena_limit)
                     ? {2'b00, cfg.arena_limit - state.commit_level} : '0;
        end
        region_pg = (region_b + {2'b00, PageMask}) & ~{2'b00, PageMask};

        // saturate the commit level at the top of the word
        commit_sum = {1'b0, region_pg} + {3'b000, state.commit_level};
        commit_new = (commit_sum > {3'b000, WordMax}) ? WordMax : commit_sum[WordW-1:0];

        trim_sum = {1'b0, req.free_from} + {{WordW{1'b0}}, 1'b1} + {{WordW{1'b0}}, 1'b1}
                 + {{WordW{1'b0}}, 1'b1};
        trim_val = (req.free_from > TrimCeiling) ? TrimCeiling
                                                 : {trim_sum[WordW-1:2], 2'b00};

        // flush image of the current state
        flushed           = state;
        flushed.next_free = '0;
        if (cfg.shrink_on_flush && (state.commit_level > cfg.min_commit_bytes)) begin
            flushed.commit_level     = cfg.min_commit_bytes;
            flushed.last_commit_tick = req.tick_now;
        end

        alloc_ok   = !room_fail && (!need_commit || req.commit_granted);
        state_next = state;
        res        = '0;

        case (req.opcode)
            OP_ALLOC: begin
                if (alloc_ok) begin
                    state_next.next_free = end_sum[WordW-1:0];
                    if (need_commit) begin
                        state_next.chunk_size       = chunk_new;
                        state_next.commit_level     = commit_new;
                        state_next.last_commit_tick = req.tick_now;
                        res.commit_grow_bytes       = commit_new - state.commit_level;
                    end
                    res.granted      = 1'b1;
                    res.block_offset = state.next_free;
                end else begin
                    // a refused commit still keeps the adapted chunk
                    state_next = flushed;
                    if (!room_fail) begin
                        state_next.chunk_size = chunk_new;
                    end
                    res.did_flush = 1'b1;
                end
            end
            OP_TRIM: begin
                state_next.next_free = trim_val;
                res.granted          = 1'b1;
            end
            OP_FLUSH: begin
                state_next    = flushed;
                res.granted   = 1'b1;
                res.did_flush = 1'b1;
            end
            default: begin
            end
        endcase

        res.commit_level_out = state_next.commit_level;
        res.next_free_out    = state_next.next_free;
    end

endmodule

`default_nettype wire

// ===== sv/adaptive_commit_bump_allocator_core.sv =====
`default_nettype none

// Bump-pointer arena allocator with adaptive commit growth. Requests enter on
// the s_ stream (opcode in s_tuser: allocate, trim tail, full flush) and each
// yields exactly one result on the m_ stream. A request passes from acceptance
// through the input register and then the allocation logic into the result
// register, and a new request is taken every clock while results are drained.
// The throughput is set by the update of the pointer, commit level, chunk size
// and last-commit tick, which each request reads and writes. Results give
// offsets relative to the arena start. The configuration registers are written
// through the cfg_ channel, always ready, and should only be changed while no
// request is in flight.
module adaptive_commit_bump_allocator_core import acba_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // request_bytes[31:0], tick_now[63:32], commit_granted[64], free_from[96:65]
    input  wire logic [InDataW-1:0]  s_tdata,
    // opcode[1:0]
    input  wire logic [1:0]          s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // granted[0], block_offset[32:1], commit_grow_bytes[64:33], did_flush[65],
    // commit_level_out[97:66], next_free_out[129:98]
    output logic [OutDataW-1:0]      m_tdata,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [WordW-1:0]    cfg_data
);

    acba_cfg_t   cfg_reg;
    acba_state_t state_reg;
    acba_state_t state_next;
    acba_req_t   in_reg;
    logic        in_valid_reg;
    acba_res_t   res_reg;
    acba_res_t   res_next;
    logic        out_valid_reg;
    logic        advance;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(OutDataW - $bits(acba_res_t)){1'b0}},
                        res_reg.next_free_out, res_reg.commit_level_out, res_reg.did_flush,
                        res_reg.commit_grow_bytes, res_reg.block_offset, res_reg.granted};

    acba_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .req        (in_reg),
        .state_next (state_next),
        .res        (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.arena_limit        <= ArenaLimitReset;
            cfg_reg.min_commit_bytes   <= MinCommitReset;
            cfg_reg.shrink_on_flush    <= 1'b1;
            cfg_reg.grow_tick_limit    <= GrowTicksReset;
            cfg_reg.shrink_tick_limit  <= ShrinkTicksReset;
            cfg_reg.chunk_ceiling      <= ChunkMaxReset;
            cfg_reg.chunk_floor        <= ChunkMinReset;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_ARENA_LIMIT:  cfg_reg.arena_limit       <= cfg_data;
                CFG_MIN_COMMIT:   cfg_reg.min_commit_bytes  <= cfg_data;
                CFG_SHRINK_FLUSH: cfg_reg.shrink_on_flush   <= cfg_data[0];
                CFG_GROW_TICKS:   cfg_reg.grow_tick_limit   <= cfg_data;
                CFG_SHRINK_TICKS: cfg_reg.shrink_tick_limit <= cfg_data;
                CFG_CHUNK_CEIL:   cfg_reg.chunk_ceiling     <= cfg_data;
                CFG_CHUNK_FLOOR:  cfg_reg.chunk_floor       <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.next_free        <= '0;
            state_reg.commit_level     <= '0;
            state_reg.chunk_size       <= ChunkReset;
            state_reg.last_commit_tick <= '0;
            in_valid_reg               <= 1'b0;
            out_valid_reg              <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg.opcode         <= s_tuser;
            in_reg.request_bytes  <= s_tdata[31:0];
            in_reg.tick_now       <= s_tdata[63:32];
            in_reg.commit_granted <= s_tdata[64];
            in_reg.free_from      <= s_tdata[96:65];
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && res_reg.did_flush |-> res_reg.next_free_out == '0)
        else $error("flush result with non-zero pointer");

    a_grow_needs_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (res_reg.commit_grow_bytes != '0) |-> res_reg.granted)
        else $error("commit growth reported on a failed request");

    a_level_echo: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> res_reg.commit_level_out == state_reg.commit_level
                    && res_reg.next_free_out == state_reg.next_free)
        else $error("result state echo differs from held state");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(state_reg))
        else $error("stalled request lost or state moved");

endmodule

`default_nettype wire
